// ----- rtl/ctpa_pkg.sv -----
// shared types and constants of the controller to player aggregator
`default_nettype none
package ctpa_pkg;

  typedef struct packed {
    logic [15:0]        device_id;
    logic [7:0]         control_code;
    logic signed [15:0] level;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  player;
    logic [15:0] button_mask;
    logic        pressed;
    logic [15:0] player_buttons;
    logic        last;
  } out_item_t;

  localparam logic [2:0] RegPlayerCount = 3'd0;
  localparam logic [2:0] RegLeftBit     = 3'd1;
  localparam logic [2:0] RegRightBit    = 3'd2;
  localparam logic [2:0] RegUpBit       = 3'd3;
  localparam logic [2:0] RegDownBit     = 3'd4;
  localparam logic [2:0] RegAxisXCode   = 3'd5;
  localparam logic [2:0] RegAxisYCode   = 3'd6;

  localparam logic [7:0] CodeConnect    = 8'h00;
  localparam logic [7:0] CodeButtonLo   = 8'h80;
  localparam logic [7:0] CodeButtonHi   = 8'h8f;
  localparam int         DeadZone       = 16;
  localparam int         NumPlayers     = 9;

  localparam logic [1:0] ZoneNeutral = 2'd0;
  localparam logic [1:0] ZonePos     = 2'd1;
  localparam logic [1:0] ZoneNeg     = 2'd2;

  typedef enum logic [4:0] {
    StIdle,
    StSearch,    // walk table reading ids
    StSearchWait,
    StDispatch,
    StShiftUp,   // open a slot for connect
    StShiftDown, // close the slot on disconnect
    StCountRd,   // per player load walk
    StCountWait,
    StPick,
    StAxis,
    StButton,
    StRelNeg,
    StPress,
    StRelease,   // disconnect release walk
    StApply,     // apply one change to a player word
    StApplyAgg,
    StEmit,
    StWriteBack
  } state_e;

endpackage
`default_nettype wire

// ----- rtl/controller_to_player_aggregator.sv -----
// top level of the controller to player aggregator
`default_nettype none
// Controller events come in one item at a time. The device table (id, player,
// held buttons and stick zones per entry) lives in one synchronous memory with
// a registered read, kept sorted by id; the player words sit in nine registers.
// An item walks the table one entry at a time, a read and then a compare, to
// find its device, a connect or disconnect shifts the entries above it one at a
// time, a first active input walks the table again to count each player's load,
// and each change of a player word gives one result (a repeat into the
// aggregate player another). How long an item takes is set by the table walks
// and by the number of results (a disconnect releases each of up to sixteen
// held buttons), plus any stalls by the receiver. Each result is held back one
// step in a holding register so that the final one can carry the last flag; it
// moves to the output register once that is free, and the walk waits while both
// are full. The next item is taken once the last result of the previous one has
// reached the output register.
module controller_to_player_aggregator #(
  parameter int MAX_DEVICES = 8
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  ctpa_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output ctpa_pkg::out_item_t  out_item_o,
  input  wire                  cfg_we_i,
  input  wire  [2:0]           cfg_index_i,
  input  wire  [7:0]           cfg_data_i
);

  localparam int IdxW = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
  localparam int CntW = $clog2(MAX_DEVICES + 1);
  localparam int CntAccW = CntW;

  typedef struct packed {
    logic [15:0] id;
    logic [3:0]  player;
    logic [15:0] buttons;
    logic [1:0]  xz;
    logic [1:0]  yz;
  } entry_t;

  // configuration registers
  logic [3:0] player_count_q, left_bit_q, right_bit_q, up_bit_q, down_bit_q;
  logic [7:0] axis_x_q, axis_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      player_count_q <= 4'd1;
      left_bit_q     <= 4'd0;
      right_bit_q    <= 4'd1;
      up_bit_q       <= 4'd2;
      down_bit_q     <= 4'd3;
      axis_x_q       <= 8'd64;
      axis_y_q       <= 8'd65;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ctpa_pkg::RegPlayerCount: player_count_q <= cfg_data_i[3:0];
        ctpa_pkg::RegLeftBit:     left_bit_q     <= cfg_data_i[3:0];
        ctpa_pkg::RegRightBit:    right_bit_q    <= cfg_data_i[3:0];
        ctpa_pkg::RegUpBit:       up_bit_q       <= cfg_data_i[3:0];
        ctpa_pkg::RegDownBit:     down_bit_q     <= cfg_data_i[3:0];
        ctpa_pkg::RegAxisXCode:   axis_x_q       <= cfg_data_i;
        ctpa_pkg::RegAxisYCode:   axis_y_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [3:0] eff_pc;
  assign eff_pc = (player_count_q > 4'd8) ? 4'd8 : player_count_q;

  // device table memory
  entry_t           mem_q [MAX_DEVICES];
  logic             mem_we;
  logic [IdxW-1:0]  mem_waddr, mem_raddr;
  entry_t           mem_wdata, mem_rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    mem_rdata_q <= mem_q[mem_raddr];
  end

  // control and working registers
  ctpa_pkg::state_e   state_q, state_d;
  ctpa_pkg::in_item_t item_q, item_d;
  logic [CntW-1:0]    count_q, count_d;   // devices in table
  logic [CntW-1:0]    idx_q, idx_d;       // walk index
  logic [CntW-1:0]    pos_q, pos_d;       // found or insert position
  logic               found_q, found_d;
  entry_t             ent_q, ent_d;       // entry being modified
  logic [15:0]        pw_q [ctpa_pkg::NumPlayers];
  logic [15:0]        pw_d [ctpa_pkg::NumPlayers];
  logic [CntAccW-1:0] load_q [ctpa_pkg::NumPlayers];
  logic [CntAccW-1:0] load_d [ctpa_pkg::NumPlayers];
  logic [3:0]         ap_q, ap_d;         // player being applied to
  logic [15:0]        am_q, am_d;         // mask being applied
  logic               apr_q, apr_d;       // press or release
  ctpa_pkg::state_e   ret_q, ret_d;       // state after the apply
  logic [1:0]         nz_q, nz_d;         // new axis zone
  logic [15:0]        held_q, held_d;     // buttons left to release
  logic               out_valid_q, out_valid_d;
  ctpa_pkg::out_item_t out_q, out_d;
  ctpa_pkg::out_item_t hold_q, hold_d;    // result held back for last flag
  logic               out_pend_q, out_pend_d; // hold register occupied

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ctpa_pkg::StIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      out_pend_q  <= 1'b0;
      for (int p = 0; p < ctpa_pkg::NumPlayers; p++) pw_q[p] <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      out_pend_q  <= out_pend_d;
      for (int p = 0; p < ctpa_pkg::NumPlayers; p++) pw_q[p] <= pw_d[p];
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    idx_q  <= idx_d;
    pos_q  <= pos_d;
    found_q <= found_d;
    ent_q  <= ent_d;
    ap_q   <= ap_d;
    am_q   <= am_d;
    apr_q  <= apr_d;
    ret_q  <= ret_d;
    nz_q   <= nz_d;
    held_q <= held_d;
    out_q  <= out_d;
    hold_q <= hold_d;
    for (int p = 0; p < ctpa_pkg::NumPlayers; p++) load_q[p] <= load_d[p];
  end

  // derived item decode
  logic is_x, is_y, is_btn, is_conn;
  logic signed [15:0] lv;
  logic [1:0] zone_new;
  assign is_conn = (item_q.control_code == ctpa_pkg::CodeConnect);
  assign is_x    = (item_q.control_code == axis_x_q);
  assign is_y    = !is_x && (item_q.control_code == axis_y_q);
  assign is_btn  = !is_x && !is_y && (item_q.control_code >= ctpa_pkg::CodeButtonLo)
                   && (item_q.control_code <= ctpa_pkg::CodeButtonHi);
  assign lv = item_q.level;
  assign zone_new = (lv >= 16'sd16) ? ctpa_pkg::ZonePos :
                    (lv <= -16'sd16) ? ctpa_pkg::ZoneNeg : ctpa_pkg::ZoneNeutral;

  logic [15:0] negm, posm, btnm;
  assign negm = is_x ? (16'd1 << left_bit_q) : (16'd1 << up_bit_q);
  assign posm = is_x ? (16'd1 << right_bit_q) : (16'd1 << down_bit_q);
  assign btnm = 16'd1 << item_q.control_code[3:0];

  logic [1:0] prev_zone;
  assign prev_zone = is_x ? ent_q.xz : ent_q.yz;

  // least loaded player search over the counted loads
  logic [3:0] best;
  always_comb begin
    best = 4'd1;
    for (int p = 2; p < ctpa_pkg::NumPlayers; p++) begin
      if ((4'(p) <= eff_pc) && (load_q[p] < load_q[best])) best = 4'(p);
    end
  end

  // highest held bit for the release walk
  logic [3:0] hi_bit;
  always_comb begin
    hi_bit = 4'd0;
    for (int b = 0; b < 16; b++) if (held_q[b]) hi_bit = 4'(b);
  end

  logic [IdxW-1:0] idx_lo, pos_lo;
  assign idx_lo = idx_q[IdxW-1:0];
  assign pos_lo = pos_q[IdxW-1:0];

  // next state and datapath
  always_comb begin
    state_d = state_q;
    item_d = item_q;
    count_d = count_q;
    idx_d = idx_q;
    pos_d = pos_q;
    found_d = found_q;
    ent_d = ent_q;
    ap_d = ap_q;
    am_d = am_q;
    apr_d = apr_q;
    ret_d = ret_q;
    nz_d = nz_q;
    held_d = held_q;
    out_d = out_q;
    hold_d = hold_q;
    out_valid_d = out_valid_q;
    out_pend_d = out_pend_q;
    for (int p = 0; p < ctpa_pkg::NumPlayers; p++) begin
      pw_d[p] = pw_q[p];
      load_d[p] = load_q[p];
    end
    mem_we = 1'b0;
    mem_waddr = pos_lo;
    mem_wdata = ent_q;
    mem_raddr = idx_lo;

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    case (state_q)
      ctpa_pkg::StIdle: begin
        if (in_valid_i && in_ready_o) begin
          item_d = in_item_i;
          idx_d = '0;
          pos_d = count_q;
          found_d = 1'b0;
          state_d = ctpa_pkg::StSearch;
        end
      end
      ctpa_pkg::StSearch: begin
        if (idx_q >= count_q) begin
          state_d = ctpa_pkg::StDispatch;
        end else begin
          mem_raddr = idx_lo;
          state_d = ctpa_pkg::StSearchWait;
        end
      end
      ctpa_pkg::StSearchWait: begin
        if (mem_rdata_q.id == item_q.device_id) begin
          found_d = 1'b1;
          pos_d = idx_q;
          ent_d = mem_rdata_q;
          state_d = ctpa_pkg::StDispatch;
        end else begin
          if (mem_rdata_q.id > item_q.device_id && pos_q == count_q) pos_d = idx_q;
          idx_d = idx_q + 1'b1;
          state_d = ctpa_pkg::StSearch;
        end
      end
      ctpa_pkg::StDispatch: begin
        state_d = ctpa_pkg::StWriteBack;
        if (is_conn) begin
          if (item_q.level != 16'sd0) begin
            if (!found_q && (count_q < CntW'(MAX_DEVICES))) begin
              idx_d = count_q;
              state_d = ctpa_pkg::StShiftUp;
            end else begin
              state_d = ctpa_pkg::StEmit;
            end
          end else if (found_q) begin
            held_d = ent_q.buttons;
            ap_d = ent_q.player;
            idx_d = pos_q;
            state_d = ctpa_pkg::StShiftDown;
          end else begin
            state_d = ctpa_pkg::StEmit;
          end
        end else if (!found_q || !(is_x || is_y || is_btn)) begin
          state_d = ctpa_pkg::StEmit;
        end else if (is_btn) begin
          if (item_q.level != 16'sd0) begin
            ret_d = ctpa_pkg::StButton;
            state_d = ctpa_pkg::StCountRd;
          end else begin
            state_d = ctpa_pkg::StButton;
          end
          idx_d = '0;
          for (int p = 0; p < ctpa_pkg::NumPlayers; p++) load_d[p] = '0;
        end else begin
          nz_d = zone_new;
          idx_d = '0;
          for (int p = 0; p < ctpa_pkg::NumPlayers; p++) load_d[p] = '0;
          if (zone_new == prev_zone) state_d = ctpa_pkg::StEmit;
          else if (zone_new != ctpa_pkg::ZoneNeutral) begin
            ret_d = ctpa_pkg::StAxis;
            state_d = ctpa_pkg::StCountRd;
          end else state_d = ctpa_pkg::StAxis;
        end
      end
      // move entries above the slot up by one, top first
      ctpa_pkg::StShiftUp: begin
        if (idx_q == pos_q) begin
          mem_we = 1'b1;
          mem_waddr = pos_lo;
          mem_wdata = '{id: item_q.device_id, player: 4'd0, buttons: 16'd0,
                        xz: 2'd0, yz: 2'd0};
          count_d = count_q + 1'b1;
          state_d = ctpa_pkg::StEmit;
        end else begin
          mem_raddr = IdxW'(idx_q - 1'b1);
          // shared read wait step
          state_d = ctpa_pkg::StCountWait;
          ret_d = ctpa_pkg::StShiftUp;
        end
      end
      // close the gap, then release the held buttons
      ctpa_pkg::StShiftDown: begin
        if (idx_q + 1'b1 >= count_q) begin
          count_d = count_q - 1'b1;
          state_d = ctpa_pkg::StRelease;
        end else begin
          mem_raddr = IdxW'(idx_q + 1'b1);
          state_d = ctpa_pkg::StCountWait;
          ret_d = ctpa_pkg::StShiftDown;
        end
      end
      // load count walk, and shared read wait for shifting
      ctpa_pkg::StCountRd: begin
        if (ent_q.player != 4'd0 || eff_pc == 4'd0) begin
          state_d = ret_q;
        end else if (idx_q >= count_q) begin
          state_d = ctpa_pkg::StPick;
        end else begin
          mem_raddr = idx_lo;
          state_d = ctpa_pkg::StCountWait;
        end
      end
      ctpa_pkg::StCountWait: begin
        if (ret_q == ctpa_pkg::StShiftUp) begin
          mem_we = 1'b1;
          mem_waddr = idx_lo;
          mem_wdata = mem_rdata_q;
          idx_d = idx_q - 1'b1;
          state_d = ctpa_pkg::StShiftUp;
        end else if (ret_q == ctpa_pkg::StShiftDown) begin
          mem_we = 1'b1;
          mem_waddr = idx_lo;
          mem_wdata = mem_rdata_q;
          idx_d = idx_q + 1'b1;
          state_d = ctpa_pkg::StShiftDown;
        end else begin
          if (mem_rdata_q.player <= eff_pc)
            load_d[mem_rdata_q.player] = load_q[mem_rdata_q.player] + 1'b1;
          idx_d = idx_q + 1'b1;
          state_d = ctpa_pkg::StCountRd;
        end
      end
      ctpa_pkg::StPick: begin
        ent_d.player = best;
        state_d = ret_q;
      end
      ctpa_pkg::StAxis: begin
        if (is_x) ent_d.xz = nz_q; else ent_d.yz = nz_q;
        state_d = ctpa_pkg::StPress;
        if (prev_zone == ctpa_pkg::ZoneNeg && (ent_q.buttons & negm) != 16'd0) begin
          ent_d.buttons = ent_q.buttons & ~negm;
          ap_d = ent_q.player; am_d = negm; apr_d = 1'b0;
          ret_d = ctpa_pkg::StPress;
          state_d = ctpa_pkg::StApply;
        end else if (prev_zone == ctpa_pkg::ZonePos && (ent_q.buttons & posm) != 16'd0) begin
          ent_d.buttons = ent_q.buttons & ~posm;
          ap_d = ent_q.player; am_d = posm; apr_d = 1'b0;
          ret_d = ctpa_pkg::StPress;
          state_d = ctpa_pkg::StApply;
        end
      end
      ctpa_pkg::StPress: begin
        state_d = ctpa_pkg::StWriteBack;
        if (nz_q == ctpa_pkg::ZoneNeg && (ent_q.buttons & negm) == 16'd0) begin
          ent_d.buttons = ent_q.buttons | negm;
          ap_d = ent_q.player; am_d = negm; apr_d = 1'b1;
          ret_d = ctpa_pkg::StWriteBack;
          state_d = ctpa_pkg::StApply;
        end else if (nz_q == ctpa_pkg::ZonePos && (ent_q.buttons & posm) == 16'd0) begin
          ent_d.buttons = ent_q.buttons | posm;
          ap_d = ent_q.player; am_d = posm; apr_d = 1'b1;
          ret_d = ctpa_pkg::StWriteBack;
          state_d = ctpa_pkg::StApply;
        end
      end
      ctpa_pkg::StButton: begin
        state_d = ctpa_pkg::StWriteBack;
        ap_d = ent_q.player; am_d = btnm; ret_d = ctpa_pkg::StWriteBack;
        if (item_q.level != 16'sd0) begin
          if ((ent_q.buttons & btnm) == 16'd0) begin
            ent_d.buttons = ent_q.buttons | btnm;
            apr_d = 1'b1;
            state_d = ctpa_pkg::StApply;
          end
        end else if ((ent_q.buttons & btnm) != 16'd0) begin
          ent_d.buttons = ent_q.buttons & ~btnm;
          apr_d = 1'b0;
          state_d = ctpa_pkg::StApply;
        end
      end
      ctpa_pkg::StRelNeg: begin
        state_d = ctpa_pkg::StRelease;
      end
      ctpa_pkg::StRelease: begin
        if (held_q == 16'd0) begin
          state_d = ctpa_pkg::StEmit;
        end else begin
          am_d = 16'd1 << hi_bit;
          held_d = held_q & ~(16'd1 << hi_bit);
          apr_d = 1'b0;
          ap_d = ent_q.player;
          ret_d = ctpa_pkg::StRelNeg;
          state_d = ctpa_pkg::StApply;
        end
      end
      // one player word update, one result; no result if the word would not change
      ctpa_pkg::StApply, ctpa_pkg::StApplyAgg: begin
        if (out_valid_q && !out_ready_i && out_pend_q) begin
          state_d = state_q;
        end else if (ap_q > eff_pc ||
                     (apr_q ? ((pw_q[ap_q] & am_q) != 16'd0)
                            : ((pw_q[ap_q] & am_q) == 16'd0))) begin
          state_d = ret_q;
        end else begin
          pw_d[ap_q] = apr_q ? (pw_q[ap_q] | am_q) : (pw_q[ap_q] & ~am_q);
          // the earlier held result moves on to the output register
          if (out_pend_q) begin
            out_d = hold_q;
            out_valid_d = 1'b1;
          end
          out_pend_d = 1'b1;
          hold_d.player = ap_q;
          hold_d.button_mask = am_q;
          hold_d.pressed = apr_q;
          hold_d.player_buttons = pw_d[ap_q];
          hold_d.last = 1'b0;
          if (ap_q != 4'd0) begin
            ap_d = 4'd0;
            state_d = ctpa_pkg::StApplyAgg;
          end else begin
            state_d = ret_q;
          end
        end
      end
      ctpa_pkg::StWriteBack: begin
        mem_we = 1'b1;
        mem_waddr = pos_lo;
        mem_wdata = ent_q;
        state_d = ctpa_pkg::StEmit;
      end
      // flush the held result with its last flag
      ctpa_pkg::StEmit: begin
        if (!out_pend_q) begin
          state_d = ctpa_pkg::StIdle;
        end else if (!out_valid_q || out_ready_i) begin
          out_d = hold_q;
          out_d.last = 1'b1;
          out_valid_d = 1'b1;
          out_pend_d = 1'b0;
          state_d = ctpa_pkg::StIdle;
        end
      end
      default: state_d = ctpa_pkg::StIdle;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o  = (state_q == ctpa_pkg::StIdle);
    out_valid_o = out_valid_q;
    out_item_o  = out_q;
  end

endmodule
`default_nettype wire
